FILE: rtl/core/ucmp_pkg.sv
// ----------------------------------------------------------------------------
// ucmp_pkg
// Shared widths, register codes and the division step of the projection
// pipeline.
// ----------------------------------------------------------------------------
package ucmp_pkg;

	localparam int DEN_W    = 50;         // magnitude of the denominator
	localparam int REM_W    = DEN_W + 1;  // partial remainder of the divider
	localparam int QB       = 41;         // quotient bits, enough for the cap
	localparam int ALPHA_W  = 17;
	localparam int ROOT_W   = 32;
	localparam int SQ_W     = 64;
	localparam int SQ_REM_W = 34;
	localparam int MAG_W    = 63;         // focal times coordinate magnitude

	localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'h10000;
	localparam logic [ALPHA_W-1:0] ALPHA_HALF = 17'h08000;
	localparam logic [QB-1:0]      QUOT_CAP   = 41'h100_0000_0000;

	typedef enum logic [2:0] {
		CFG_FOCAL_X  = 3'd0,
		CFG_FOCAL_Y  = 3'd1,
		CFG_CENTER_X = 3'd2,
		CFG_CENTER_Y = 3'd3,
		CFG_ALPHA    = 3'd4
	} cfg_idx_t;

	// The numerator bits shift out at the top while quotient bits enter at
	// the bottom, so after QB steps the field holds the quotient.
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QB-1:0]    bits;
	} div_lane_t;

	function automatic div_lane_t div_step(input div_lane_t cur,
			input logic [DEN_W-1:0] dm);
		logic [REM_W-1:0] t;
		logic             ge;
		div_lane_t        nxt;
		t  = {cur.rem[REM_W-2:0], cur.bits[QB-1]};
		ge = (t >= {1'b0, dm});
		nxt.rem  = ge ? (t - {1'b0, dm}) : t;
		nxt.bits = {cur.bits[QB-2:0], ge};
		return nxt;
	endfunction

endpackage

FILE: rtl/core/ucmp_div.sv
// ----------------------------------------------------------------------------
// ucmp_div
// Pipelined restoring divider for both image axes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ucmp_div (
	input  logic                         clk,
	input  logic                         en,
	input  ucmp_pkg::div_lane_t          lane_in [2],
	input  logic [ucmp_pkg::DEN_W-1:0]   dm_in,
	output ucmp_pkg::div_lane_t          lane_out [2],
	output logic [ucmp_pkg::DEN_W-1:0]   dm_out
);

	ucmp_pkg::div_lane_t              lane_s [ucmp_pkg::QB][2];
	logic [ucmp_pkg::DEN_W-1:0]       dm_s   [ucmp_pkg::QB];

	for (genvar i = 0; i < ucmp_pkg::QB; i++) begin : g_stage
		ucmp_pkg::div_lane_t        cur [2];
		logic [ucmp_pkg::DEN_W-1:0] dcur;

		if (i == 0) begin : g_first
			assign cur  = lane_in;
			assign dcur = dm_in;
		end else begin : g_next
			assign cur  = lane_s[i-1];
			assign dcur = dm_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lane_s[i][0] <= ucmp_pkg::div_step(cur[0], dcur);
				lane_s[i][1] <= ucmp_pkg::div_step(cur[1], dcur);
				dm_s[i]      <= dcur;
			end
		end
	end

	assign lane_out = lane_s[ucmp_pkg::QB-1];
	assign dm_out   = dm_s[ucmp_pkg::QB-1];

endmodule

FILE: rtl/core/ucm_point_projection.sv
// ----------------------------------------------------------------------------
// ucm_point_projection
// Unified camera model projection of a Q16.16 point to pixel coordinates.
// ----------------------------------------------------------------------------
// Throughput: one point per cycle; the 32-stage square root and the 41-stage
// divider each retire one item per cycle, and the whole pipeline halts only
// while a waiting result is stalled.
// Reset: valid bits clear at once and the registers return to fx = fy = 1.0,
// cx = cy = 0 and alpha = 0.5; there is no clearing pass.
module ucm_point_projection #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic               check_validity,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pixel_u,
	output logic signed [31:0] pixel_v,
	output logic               valid_res,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int NSQ = ucmp_pkg::ROOT_W;
	localparam int QB  = ucmp_pkg::QB;
	localparam logic [31:0] FOCAL_ONE = 32'(64'd1 << FRAC_BITS);
	localparam logic [31:0] NEG_ONE   = ~FOCAL_ONE + 32'd1;
	localparam logic [63:0] DEN_THR   = (64'd1 << (FRAC_BITS + 16)) / 64'd1000;

	typedef struct packed {
		logic                               chk;
		logic                               xneg;
		logic                               yneg;
		logic signed [31:0]                 z;
		logic [ucmp_pkg::MAG_W-1:0]         mx;
		logic [ucmp_pkg::MAG_W-1:0]         my;
	} sb_t;

	typedef struct packed {
		logic [ucmp_pkg::SQ_REM_W-1:0] rem;
		logic [ucmp_pkg::ROOT_W-1:0]   root;
		logic [ucmp_pkg::SQ_W-1:0]     sq;
	} sqr_t;

	typedef struct packed {
		logic rej;
		logic negu;
		logic negv;
		logic ovu;
		logic ovv;
		logic zu;
		logic zv;
	} dsb_t;

	// Configuration registers.
	logic [31:0]                    focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic [ucmp_pkg::ALPHA_W-1:0]   alpha_q;
	logic [ucmp_pkg::ALPHA_W-1:0]   alpha_eff, gamma_eff;
	logic                           alpha_hi;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= FOCAL_ONE;
			focal_y_q  <= FOCAL_ONE;
			center_x_q <= '0;
			center_y_q <= '0;
			alpha_q    <= ucmp_pkg::ALPHA_HALF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ucmp_pkg::CFG_FOCAL_X:  focal_x_q  <= cfg_data;
				ucmp_pkg::CFG_FOCAL_Y:  focal_y_q  <= cfg_data;
				ucmp_pkg::CFG_CENTER_X: center_x_q <= cfg_data;
				ucmp_pkg::CFG_CENTER_Y: center_y_q <= cfg_data;
				ucmp_pkg::CFG_ALPHA:    alpha_q    <= cfg_data[ucmp_pkg::ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	assign alpha_eff = (alpha_q > ucmp_pkg::ALPHA_ONE) ? ucmp_pkg::ALPHA_ONE : alpha_q;
	assign gamma_eff = ucmp_pkg::ALPHA_ONE - alpha_eff;
	assign alpha_hi  = (alpha_eff > ucmp_pkg::ALPHA_HALF);

	// The whole pipeline moves together unless the result in the output
	// register is held by the consumer.
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// ------------------------------------------------------------------ s1
	logic               v_s1, chk_s1;
	logic signed [31:0] x_s1, y_s1, z_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= point_x;
			y_s1   <= point_y;
			z_s1   <= point_z;
			chk_s1 <= check_validity;
		end
	end

	// ------------------------------------------------------------------ s2
	logic                         v_s2;
	logic [62:0]                  xx_s2, yy_s2, zz_s2;
	sb_t                          sb_s2;
	logic signed [63:0]           xx_w, yy_w, zz_w;
	logic [31:0]                  ax_w, ay_w;
	logic [63:0]                  mx_w, my_w;

	assign xx_w = x_s1 * x_s1;
	assign yy_w = y_s1 * y_s1;
	assign zz_w = z_s1 * z_s1;
	assign ax_w = x_s1[31] ? 32'(-x_s1) : 32'(x_s1);
	assign ay_w = y_s1[31] ? 32'(-y_s1) : 32'(y_s1);
	assign mx_w = 64'(focal_x_q) * 64'(ax_w);
	assign my_w = 64'(focal_y_q) * 64'(ay_w);

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s2      <= xx_w[62:0];
			yy_s2      <= yy_w[62:0];
			zz_s2      <= zz_w[62:0];
			sb_s2.chk  <= chk_s1;
			sb_s2.xneg <= x_s1[31];
			sb_s2.yneg <= y_s1[31];
			sb_s2.z    <= z_s1;
			sb_s2.mx   <= mx_w[62:0];
			sb_s2.my   <= my_w[62:0];
		end
	end

	// ------------------------------------------------------------------ s3
	logic        v_s3;
	logic [63:0] sq_s3;
	sb_t         sb_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3 <= {1'b0, xx_s2} + {1'b0, yy_s2} + {1'b0, zz_s2};
			sb_s3 <= sb_s2;
		end
	end

	// ------------------------------------------------------- square root
	// Restoring digit recurrence, two radicand bits per stage.
	sqr_t sqr_s [NSQ];
	sb_t  sqsb_s [NSQ];
	logic sqv_s [NSQ];

	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		sqr_t        cur;
		sb_t         sbc;
		logic        vc;
		logic [35:0] t, trial;
		logic        ge;

		if (k == 0) begin : g_first
			assign cur = '{rem: '0, root: '0, sq: sq_s3};
			assign sbc = sb_s3;
			assign vc  = v_s3;
		end else begin : g_next
			assign cur = sqr_s[k-1];
			assign sbc = sqsb_s[k-1];
			assign vc  = sqv_s[k-1];
		end

		assign t     = {cur.rem, cur.sq[63-2*k -: 2]};
		assign trial = {2'b00, cur.root, 2'b01};
		assign ge    = (t >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				sqr_s[k].rem  <= ge ? ucmp_pkg::SQ_REM_W'(t - trial)
					: ucmp_pkg::SQ_REM_W'(t);
				sqr_s[k].root <= {cur.root[ucmp_pkg::ROOT_W-2:0], ge};
				sqr_s[k].sq   <= cur.sq;
				sqsb_s[k]     <= sbc;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqv_s[k] <= 1'b0;
			end else if (en) begin
				sqv_s[k] <= vc;
			end
		end
	end

	logic [31:0] d_w;
	sb_t         sbd_w;
	assign d_w   = sqr_s[NSQ-1].root;
	assign sbd_w = sqsb_s[NSQ-1];

	// ------------------------------------------------------------------ s4
	logic               v_s4;
	logic [48:0]        ad_s4, gd_s4;
	logic signed [49:0] gz_s4, za_s4;
	sb_t                sb_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ad_s4 <= 49'(alpha_eff) * 49'(d_w);
			gd_s4 <= 49'(gamma_eff) * 49'(d_w);
			gz_s4 <= $signed(50'(gamma_eff)) * 50'(sbd_w.z);
			za_s4 <= $signed(50'(alpha_eff)) * 50'(sbd_w.z);
			sb_s4 <= sbd_w;
		end
	end

	// ------------------------------------------------------------------ s5
	logic               v_s5;
	logic signed [50:0] den_s5, vis_s5;
	sb_t                sb_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s5 <= $signed(51'(ad_s4)) + 51'(gz_s4);
			vis_s5 <= $signed(51'(gd_s4)) + 51'(za_s4);
			sb_s5  <= sb_s4;
		end
	end

	// ------------------------------------------------------------------ s6
	logic                         v_s6, rej_s6, negu_s6, negv_s6;
	logic [ucmp_pkg::DEN_W-1:0]   dm_s6;
	logic [ucmp_pkg::MAG_W-1:0]   mx_s6, my_s6;
	logic signed [50:0]           vis_w, dabs_w;
	logic                         small_w, hidden_w;

	assign vis_w    = alpha_hi ? vis_s5 : den_s5;
	assign small_w  = den_s5[50] || (den_s5[49:0] <= DEN_THR[49:0]);
	assign hidden_w = vis_w[50] || (vis_w == '0);
	assign dabs_w   = den_s5[50] ? -den_s5 : den_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			rej_s6  <= sb_s5.chk && (small_w || hidden_w);
			negu_s6 <= sb_s5.xneg ^ den_s5[50];
			negv_s6 <= sb_s5.yneg ^ den_s5[50];
			dm_s6   <= dabs_w[ucmp_pkg::DEN_W-1:0];
			mx_s6   <= sb_s5.mx;
			my_s6   <= sb_s5.my;
		end
	end

	// ------------------------------------------------------------------ s7
	// The numerator is mag << 16; its top bits seed the remainder. When they
	// already reach the divisor the quotient exceeds the cap.
	logic                       v_s7;
	dsb_t                       dsb_s7;
	ucmp_pkg::div_lane_t        lane_s7 [2];
	logic [ucmp_pkg::DEN_W-1:0] dm_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			dsb_s7.rej   <= rej_s6;
			dsb_s7.negu  <= negu_s6;
			dsb_s7.negv  <= negv_s6;
			dsb_s7.ovu   <= (50'(mx_s6[62:25]) >= dm_s6);
			dsb_s7.ovv   <= (50'(my_s6[62:25]) >= dm_s6);
			dsb_s7.zu    <= (mx_s6 == '0);
			dsb_s7.zv    <= (my_s6 == '0);
			lane_s7[0].rem  <= ucmp_pkg::REM_W'(mx_s6[62:25]);
			lane_s7[0].bits <= {mx_s6[24:0], 16'b0};
			lane_s7[1].rem  <= ucmp_pkg::REM_W'(my_s6[62:25]);
			lane_s7[1].bits <= {my_s6[24:0], 16'b0};
			dm_s7        <= dm_s6;
		end
	end

	// ------------------------------------------------------------- divide
	ucmp_pkg::div_lane_t        lane_q [2];
	logic [ucmp_pkg::DEN_W-1:0] dm_q;

	ucmp_div u_div (
		.clk      (clk),
		.en       (en),
		.lane_in  (lane_s7),
		.dm_in    (dm_s7),
		.lane_out (lane_q),
		.dm_out   (dm_q)
	);

	dsb_t dsb_s [QB];
	logic dv_s  [QB];

	for (genvar i = 0; i < QB; i++) begin : g_dsb
		dsb_t bc;
		logic vc;

		if (i == 0) begin : g_first
			assign bc = dsb_s7;
			assign vc = v_s7;
		end else begin : g_next
			assign bc = dsb_s[i-1];
			assign vc = dv_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dsb_s[i] <= bc;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[i] <= 1'b0;
			end else if (en) begin
				dv_s[i] <= vc;
			end
		end
	end

	// ------------------------------------------------------------------ s8
	logic               v_s8, rej_s8;
	logic signed [41:0] qu_s8, qv_s8;
	dsb_t               dq_w;
	logic [41:0]        ru_w, rv_w, cu_w, cv_w;

	assign dq_w = dsb_s[QB-1];

	// Round to nearest, ties away from zero, then cap the magnitude; a zero numerator gives zero.
	always_comb begin
		ru_w = {1'b0, lane_q[0].bits}
			+ 42'({lane_q[0].rem[ucmp_pkg::REM_W-2:0], 1'b0} >= {1'b0, dm_q});
		rv_w = {1'b0, lane_q[1].bits}
			+ 42'({lane_q[1].rem[ucmp_pkg::REM_W-2:0], 1'b0} >= {1'b0, dm_q});
		if (dq_w.zu) begin
			cu_w = '0;
		end else if (dq_w.ovu || ru_w > {1'b0, ucmp_pkg::QUOT_CAP}) begin
			cu_w = {1'b0, ucmp_pkg::QUOT_CAP};
		end else begin
			cu_w = ru_w;
		end
		if (dq_w.zv) begin
			cv_w = '0;
		end else if (dq_w.ovv || rv_w > {1'b0, ucmp_pkg::QUOT_CAP}) begin
			cv_w = {1'b0, ucmp_pkg::QUOT_CAP};
		end else begin
			cv_w = rv_w;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qu_s8  <= dq_w.negu ? -$signed(cu_w) : $signed(cu_w);
			qv_s8  <= dq_w.negv ? -$signed(cv_w) : $signed(cv_w);
			rej_s8 <= dq_w.rej;
		end
	end

	// ------------------------------------------------------------------ s9
	logic               v_s9, valid_s9;
	logic signed [31:0] u_s9, v9_s9;
	logic signed [42:0] su_w, sv_w;
	logic signed [31:0] cu32_w, cv32_w;

	assign su_w = 43'(qu_s8) + $signed(43'(center_x_q));
	assign sv_w = 43'(qv_s8) + $signed(43'(center_y_q));

	always_comb begin
		if (su_w > 43'sd2147483647) begin
			cu32_w = 32'sh7FFF_FFFF;
		end else if (su_w < -43'sd2147483648) begin
			cu32_w = 32'sh8000_0000;
		end else begin
			cu32_w = su_w[31:0];
		end
		if (sv_w > 43'sd2147483647) begin
			cv32_w = 32'sh7FFF_FFFF;
		end else if (sv_w < -43'sd2147483648) begin
			cv32_w = 32'sh8000_0000;
		end else begin
			cv32_w = sv_w[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s9     <= rej_s8 ? $signed(NEG_ONE) : cu32_w;
			v9_s9    <= rej_s8 ? $signed(NEG_ONE) : cv32_w;
			valid_s9 <= !rej_s8;
		end
	end

	// Valid bits of the named stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= sqv_s[NSQ-1];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= dv_s[QB-1];
			v_s9 <= v_s8;
		end
	end

	assign out_valid = v_s9;
	assign pixel_u   = u_s9;
	assign pixel_v   = v9_s9;
	assign valid_res = valid_s9;

endmodule

FILE: verif/tb_ucm_point_projection.sv
// ----------------------------------------------------------------------------
// tb_ucm_point_projection
// Self-checking bench for the unified camera model projection. An in-bench
// predictor works out the pixel coordinates and validity of every accepted
// point, and the monitor compares each output transaction with the oldest
// prediction. Several register settings, the extremes among them, are
// visited, and the sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_ucm_point_projection;

	localparam int  FRAC       = 16;
	localparam int  SETTLE     = 100;
	localparam int  CYCLE_CAP  = 600000;
	localparam int  PHASE_LEN  = 230;
	localparam longint unsigned CAP40 = 64'd1 << 40;

	typedef struct {
		logic signed [31:0] x, y, z;
		logic               chk;
	} point_t;

	typedef struct {
		logic signed [31:0] u, v;
		logic               ok;
	} pixel_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] point_x = '0;
	logic signed [31:0] point_y = '0;
	logic signed [31:0] point_z = '0;
	logic               check_validity = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] pixel_u;
	logic signed [31:0] pixel_v;
	logic               valid_res;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	// Register copies used by the predictor.
	logic [31:0] focal_u = 32'h0001_0000;
	logic [31:0] focal_v = 32'h0001_0000;
	logic [31:0] centre_u = '0;
	logic [31:0] centre_v = '0;
	logic [16:0] alpha_q = 17'h08000;

	point_t pending_points[$];
	pixel_t expected_pixels[$];
	int     mismatches = 0;
	int     cycles = 0;
	bit     quiet = 1'b0;
	int     send_gap = 0;
	int     stall_gap = 0;

	ucm_point_projection #(.FRAC_BITS(FRAC)) dut (.*);

	always #10 clk = ~clk;

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	// Focal times coordinate over the denominator, rounded half away from zero,
	// capped at 2^40, then offset by the centre and saturated to 32 bits.
	function automatic logic [31:0] axis_pixel(logic [31:0] f, longint p, longint den,
			logic [31:0] c);
		logic            neg;
		longint unsigned m, dm, q;
		bit [127:0]      num, quo, rem;
		longint          s;
		neg = (p < 0) != (den < 0);
		m = longint'(f) * magnitude(p);
		dm = magnitude(den);
		if (m == 0) begin
			q = 0;
		end else if (dm == 0) begin
			q = CAP40;
			neg = (p < 0);
		end else begin
			num = {64'd0, m} << 16;
			quo = num / dm;
			rem = num % dm;
			if (quo > CAP40) begin
				q = CAP40;
			end else begin
				q = quo[63:0];
				if (2 * rem[63:0] >= dm) q++;
				if (q > CAP40) q = CAP40;
			end
		end
		s = neg ? -longint'(q) : longint'(q);
		s += longint'(c);
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		return s[31:0];
	endfunction

	function automatic pixel_t project_point(point_t pt);
		longint          x, y, z, a, g, d, den, vis;
		longint unsigned sq;
		pixel_t          r;
		x = pt.x;
		y = pt.y;
		z = pt.z;
		a = (alpha_q > ucmp_pkg::ALPHA_ONE) ? 64'sd65536 : longint'(alpha_q);
		g = 64'sd65536 - a;
		sq = longint'(x * x) + longint'(y * y) + longint'(z * z);
		d = root_floor(sq);
		den = a * d + g * z;
		r.ok = 1'b1;
		if (pt.chk) begin
			vis = (a <= 64'sd32768) ? den : (z * a + g * d);
			if (den * 1000 < (64'sd1 <<< (FRAC + 16)) || vis <= 0) r.ok = 1'b0;
		end
		if (!r.ok) begin
			r.u = -(32'sd1 <<< FRAC);
			r.v = -(32'sd1 <<< FRAC);
		end else begin
			r.u = axis_pixel(focal_u, x, den, centre_u);
			r.v = axis_pixel(focal_v, y, den, centre_v);
		end
		return r;
	endfunction

	// Sender: one transaction per handshake, idle bursts between points.
	always @(posedge clk or negedge arst_n) begin
		point_t pt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				pt.x = point_x;
				pt.y = point_y;
				pt.z = point_z;
				pt.chk = check_validity;
				expected_pixels.push_back(project_point(pt));
			end
			if (!(in_valid && in_stall)) begin
				if (send_gap > 0 && !quiet) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 6);
					in_valid <= 1'b0;
				end else if (pending_points.size() > 0) begin
					pt = pending_points.pop_front();
					in_valid <= 1'b1;
					point_x <= pt.x;
					point_y <= pt.y;
					point_z <= pt.z;
					check_validity <= pt.chk;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stall bursts and the comparison against predictions.
	always @(posedge clk or negedge arst_n) begin
		pixel_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result u=%h v=%h ok=%b", $time, pixel_u,
						pixel_v, valid_res);
				end else begin
					e = expected_pixels.pop_front();
					if (pixel_u !== e.u) begin
						mismatches++;
						$display("%0t: pixel_u expected %h actual %h", $time, e.u, pixel_u);
					end
					if (pixel_v !== e.v) begin
						mismatches++;
						$display("%0t: pixel_v expected %h actual %h", $time, e.v, pixel_v);
					end
					if (valid_res !== e.ok) begin
						mismatches++;
						$display("%0t: valid_res expected %b actual %b", $time, e.ok,
							valid_res);
					end
				end
			end
			if (quiet) begin
				out_stall <= 1'b0;
			end else if (stall_gap > 0) begin
				stall_gap--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 7) == 0) begin
				stall_gap = $urandom_range(0, 6);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_CAP) begin
			$display("** ucm_point_projection: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(ucmp_pkg::cfg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			ucmp_pkg::CFG_FOCAL_X: focal_u = value;
			ucmp_pkg::CFG_FOCAL_Y: focal_v = value;
			ucmp_pkg::CFG_CENTER_X: centre_u = value;
			ucmp_pkg::CFG_CENTER_Y: centre_v = value;
			ucmp_pkg::CFG_ALPHA: alpha_q = value[16:0];
			default: ;
		endcase
	endtask

	task automatic set_camera(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx,
			logic [31:0] cy, logic [31:0] al);
		write_reg(ucmp_pkg::CFG_FOCAL_X, fx);
		write_reg(ucmp_pkg::CFG_FOCAL_Y, fy);
		write_reg(ucmp_pkg::CFG_CENTER_X, cx);
		write_reg(ucmp_pkg::CFG_CENTER_Y, cy);
		write_reg(ucmp_pkg::CFG_ALPHA, al);
	endtask

	task automatic add_point(int x, int y, int z, bit chk);
		point_t pt;
		pt.x = x;
		pt.y = y;
		pt.z = z;
		pt.chk = chk;
		pending_points.push_back(pt);
	endtask

	function automatic int coord(int mode);
		int pick;
		case (mode)
			0, 1, 2, 3: return int'($urandom_range(0, 4194304)) - 2097152;
			4, 5: return int'($urandom);
			6: return int'($urandom_range(0, 134217728)) - 67108864;
			7: return ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 65535));
			default: begin
				pick = $urandom_range(0, 4);
				case (pick)
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 0;
					3: return 1;
					default: return -1;
				endcase
			end
		endcase
	endfunction

	task automatic add_random_points(int n);
		int mode, x, y, z;
		repeat (n) begin
			mode = $urandom_range(0, 9);
			x = coord(mode);
			y = coord(mode);
			z = coord(mode);
			// In modes 0 to 3, mostly points in front of the camera so the projection path is used.
			if (mode < 4 && $urandom_range(0, 3) != 0) z = (z < 0) ? -z : z;
			if (mode == 7 && $urandom_range(0, 1) == 0) begin
				x = 0;
				y = 0;
				z = -int'($urandom_range(0, 1 << 20));
			end
			add_point(x, y, z, $urandom_range(0, 3) != 0);
		end
	endtask

	task automatic drain();
		while (pending_points.size() > 0 || in_valid || expected_pixels.size() > 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		logic [31:0] al;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: origin, unit axes, extremes, points behind and grazing.
		add_point(0, 0, 0, 1'b0);
		add_point(0, 0, 0, 1'b1);
		add_point(65536, 0, 65536, 1'b1);
		add_point(0, -65536, 65536, 1'b1);
		add_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1);
		add_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
		add_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
		add_point(1, -1, 1, 1'b1);
		add_point(65536, 65536, -65536 * 4, 1'b1);
		add_point(65536, 65536, -65536 * 4, 1'b0);
		add_point(0, 0, -65536, 1'b1);
		add_point(0, 0, -65536, 1'b0);
		add_point(100, 0, 0, 1'b1);
		add_point(-300000, 700000, 10, 1'b1);
		drain();

		// Largest focal lengths and centres with alpha of zero: the denominator
		// is zero for every point on the Z = 0 plane.
		set_camera(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
		add_point(5 << 16, -(3 << 16), 0, 1'b0);
		add_point(5 << 16, -(3 << 16), 0, 1'b1);
		add_point(0, 7, 0, 1'b0);
		add_point(-9, 0, 0, 1'b0);
		add_point(1 << 16, 1 << 16, 1, 1'b1);
		add_random_points(PHASE_LEN);
		drain();

		set_camera(0, 0, 0, 0, 32'h0001_0000);
		add_random_points(PHASE_LEN);
		drain();

		// Alpha above one acts as one.
		set_camera(500 << 16, 480 << 16, 320 << 16, 240 << 16, 32'h0001_ffff);
		add_random_points(PHASE_LEN);
		drain();

		set_camera(300 << 16, 300 << 16, 640 << 16, 360 << 16, 32'h0000_8001);
		add_random_points(PHASE_LEN);
		drain();

		repeat (2) begin
			al = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 32'h1ffff)
				: $urandom_range(0, 65536);
			set_camera($urandom_range(0, 2000 << 16), $urandom, $urandom_range(0, 1 << 26),
				$urandom, al);
			add_random_points(PHASE_LEN);
			drain();
		end

		quiet = 1'b1;
		set_camera($urandom_range(100 << 16, 900 << 16), $urandom_range(100 << 16, 900 << 16),
			$urandom_range(0, 1000 << 16), $urandom_range(0, 1000 << 16),
			$urandom_range(0, 65536));
		add_random_points(PHASE_LEN);
		drain();

		if (mismatches == 0) begin
			$display("** ucm_point_projection: PASSED **");
		end else begin
			$display("** ucm_point_projection: FAILED **");
		end
		$finish;
	end

endmodule
